// ===== src/page_residency_cache_controller_top_assert.svh =====
// Assertion macros for the page residency cache controller top level.
// Uses only standard concurrent assertion syntax; no other dependencies.
`ifndef PAGE_RESIDENCY_CACHE_CONTROLLER_TOP_ASSERT_SVH
`define PAGE_RESIDENCY_CACHE_CONTROLLER_TOP_ASSERT_SVH

// Assert an implication that is checked on every rising clock edge out of reset.
`define PRC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert an implication whose consequent is checked in the cycle after the antecedent.
`define PRC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/prcc_pkg.sv =====
// Shared types and constants for the page residency cache controller.
// Used by the controller, the datapath and the top level; no dependencies.
package prcc_pkg;

    localparam int unsigned PAGE_W = 24;
    localparam int unsigned GEN_W  = 32;
    localparam int unsigned PCNT_W = 25;
    localparam int unsigned AGE_W  = 64;

    // Operation codes.
    localparam logic [1:0] OP_LOOKUP  = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_SERVICE = 2'd2;
    localparam logic [1:0] OP_LOAD    = 2'd3;

    // Result status codes.
    localparam logic [3:0] ST_HIT       = 4'd0;
    localparam logic [3:0] ST_MISS      = 4'd1;
    localparam logic [3:0] ST_RANGE     = 4'd2;
    localparam logic [3:0] ST_RELEASED  = 4'd3;
    localparam logic [3:0] ST_REL_ERR   = 4'd4;
    localparam logic [3:0] ST_IDLE      = 4'd5;
    localparam logic [3:0] ST_STALE     = 4'd6;
    localparam logic [3:0] ST_NO_SLOT   = 4'd7;
    localparam logic [3:0] ST_FETCH     = 4'd8;
    localparam logic [3:0] ST_CORRUPT   = 4'd9;
    localparam logic [3:0] ST_PUBLISHED = 4'd10;

    // Enqueue outcomes.
    localparam logic [1:0] EQ_NONE     = 2'd0;
    localparam logic [1:0] EQ_QUEUED   = 2'd1;
    localparam logic [1:0] EQ_COALESCE = 2'd2;
    localparam logic [1:0] EQ_FULL     = 2'd3;

    // Slot and queue entry states.
    localparam logic [1:0] SS_EMPTY   = 2'd0;
    localparam logic [1:0] SS_LOADING = 2'd1;
    localparam logic [1:0] SS_READY   = 2'd2;
    localparam logic [1:0] QS_FREE     = 2'd0;
    localparam logic [1:0] QS_DEMAND   = 2'd1;
    localparam logic [1:0] QS_PREFETCH = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_PAGE_COUNT = 1'b0;
    localparam logic CFG_ACTIVE_GEN = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_CHECK,
        S_SECOND,
        S_ENQ,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // register the input word
        logic eval;      // first phase: decode, then first lookup, release, service pick or load
        logic second;    // second page of a two-page lookup
        logic enq;       // run a pending enqueue
        logic emit;      // result goes to the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_second;
        logic need_enq;
    } t_stat;

    // One result word.
    typedef struct packed {
        logic [1:0]        enqueue_outcome;
        logic              victim_evicted;
        logic              fetch_is_prefetch;
        logic [3:0]        fetch_slot;
        logic [PAGE_W-1:0] page_number;
        logic              spans_two_pages;
        logic [3:0]        second_slot;
        logic [3:0]        first_slot;
        logic [3:0]        status;
    } t_result;

endpackage

// ===== src/prcc_ctrl.sv =====
// Controller state machine of the page residency cache controller.
// Depends on prcc_pkg; drives the datapath through t_cmd and reads t_stat.
module prcc_ctrl
    import prcc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state. The datapath flags are registered, so they are examined
    // in a check cycle after each phase that can raise them.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EVAL;
            end
            S_EVAL: n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.need_second) n_state = S_SECOND;
                else if (i_stat.need_enq) n_state = S_ENQ;
                else n_state = S_OUT;
            end
            S_SECOND: n_state = S_CHECK;
            S_ENQ: n_state = S_OUT;
            S_OUT: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EVAL:   o_cmd.eval = 1'b1;
            S_CHECK:  o_cmd = '0;
            S_SECOND: o_cmd.second = 1'b1;
            S_ENQ:    o_cmd.enq = 1'b1;
            S_OUT:    o_cmd.emit = i_out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== src/prcc_dpath.sv =====
// Datapath of the page residency cache controller: slot tags, fetch queue.
// Depends on prcc_pkg; sequenced by prcc_ctrl through t_cmd.
module prcc_dpath
    import prcc_pkg::*;
#(
    parameter int unsigned PAGE_FRAMES = 256,
    parameter int unsigned SLOT_COUNT  = 16,
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [1:0]         i_operation,
    input  logic [31:0]        i_start_frame,
    input  logic [15:0]        i_frame_count,
    input  logic [3:0]         i_slot_index,
    input  logic               i_load_ok,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [GEN_W-1:0]   i_cfg_data,
    output t_result            o_result
);

    localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned FSH = $clog2(PAGE_FRAMES);
    localparam int unsigned END_W = PCNT_W + FSH + 1;
    localparam int unsigned NP = 1 << SW;

    // Configuration registers.
    logic [PCNT_W-1:0] r_page_count;
    logic [GEN_W-1:0]  r_active_gen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= '0;
            r_active_gen <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_PAGE_COUNT) r_page_count <= i_cfg_data[PCNT_W-1:0];
            else r_active_gen <= i_cfg_data;
        end
    end

    // Captured input word.
    logic [1:0]  r_op;
    logic [31:0] r_start;
    logic [15:0] r_count;
    logic [3:0]  r_sidx;
    logic        r_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_operation;
            r_start <= i_start_frame;
            r_count <= i_frame_count;
            r_sidx  <= i_slot_index;
            r_ok    <= i_load_ok;
        end
    end

    // Slot and queue state.
    logic [1:0]        r_sstat [SLOT_COUNT];
    logic [PAGE_W-1:0] r_spage [SLOT_COUNT];
    logic [GEN_W-1:0]  r_sgen  [SLOT_COUNT];
    logic [7:0]        r_spin  [SLOT_COUNT];
    logic [AGE_W-1:0]  r_sage  [SLOT_COUNT];
    logic              r_sdem  [SLOT_COUNT];
    logic [1:0]        r_qstat [QUEUE_DEPTH];
    logic [PAGE_W-1:0] r_qpage [QUEUE_DEPTH];
    logic [GEN_W-1:0]  r_qgen  [QUEUE_DEPTH];
    logic [AGE_W-1:0]  r_clock;

    // Work registers held between phases.
    t_result           r_res;
    logic              r_need_second;
    logic              r_need_enq;
    logic              r_enq_pf;
    logic [PAGE_W-1:0] r_enq_page;
    logic [PAGE_W-1:0] r_last_page;
    logic [SW-1:0]     r_first_hit;

    // Range check and page split.
    logic [32:0]      end_frame;
    logic [END_W-1:0] limit;
    logic [32:0]      last_frame;
    logic [31:0]      first_pg_full, last_pg_full;
    logic             range_bad;
    logic             spans;

    always_comb begin
        end_frame = {1'b0, r_start} + {17'd0, r_count};
        limit = END_W'(r_page_count) << FSH;
        last_frame = end_frame - 33'd1;
        first_pg_full = r_start >> FSH;
        last_pg_full = 32'(last_frame >> FSH);
        range_bad = (r_count == 16'd0) || ({16'd0, r_count} > 32'(2 * PAGE_FRAMES))
            || ({{(END_W > 33 ? END_W - 33 : 0){1'b0}}, end_frame} > END_W'(limit))
            || ((last_pg_full - first_pg_full) > 32'd1);
        spans = last_pg_full != first_pg_full;
    end

    // Tag match for a page: lowest ready slot of the active generation.
    logic [PAGE_W-1:0] look_page;
    logic              hit_found;
    logic [SW-1:0]     hit_idx;

    always_comb begin
        look_page = i_cmd.second ? r_last_page : first_pg_full[PAGE_W-1:0];
        hit_found = 1'b0;
        hit_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_sstat[i] == SS_READY && r_spage[i] == look_page
                && r_sgen[i] == r_active_gen) begin
                hit_found = 1'b1;
                hit_idx = SW'(i);
            end
        end
    end

    // Queue pick: lowest demand entry, else lowest prefetch entry.
    logic          q_dem_found, q_pf_found;
    logic [QW-1:0] q_dem_idx, q_pf_idx, q_idx;

    always_comb begin
        q_dem_found = 1'b0;
        q_pf_found = 1'b0;
        q_dem_idx = '0;
        q_pf_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (r_qstat[i] == QS_DEMAND) begin
                q_dem_found = 1'b1;
                q_dem_idx = QW'(i);
            end
            if (r_qstat[i] == QS_PREFETCH) begin
                q_pf_found = 1'b1;
                q_pf_idx = QW'(i);
            end
        end
        q_idx = q_dem_found ? q_dem_idx : q_pf_idx;
    end

    // Slot pick: first empty slot, else oldest unpinned ready slot.
    // The oldest slot is found by a compare tree; on equal ages the lower index stays.
    logic          s_empty_found, s_best_found, s_found;
    logic [SW-1:0] s_empty_idx, s_best_idx, s_idx;
    logic             c_ok  [NP];
    logic [SW-1:0]    c_idx [NP];
    logic [AGE_W-1:0] c_age [NP];

    always_comb begin
        s_empty_found = 1'b0;
        s_empty_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (r_sstat[i] == SS_EMPTY) begin
                s_empty_found = 1'b1;
                s_empty_idx = SW'(i);
            end
        end
        for (int i = 0; i < NP; i++) begin
            c_ok[i]  = 1'b0;
            c_idx[i] = SW'(i);
            c_age[i] = '0;
        end
        for (int i = 0; i < SLOT_COUNT; i++) begin
            c_ok[i]  = r_sstat[i] == SS_READY && r_spin[i] == 8'd0;
            c_age[i] = r_sage[i];
        end
        for (int w = 1; w < NP; w = w * 2) begin
            for (int i = 0; i + w < NP; i = i + 2 * w) begin
                if (c_ok[i + w] && (!c_ok[i] || c_age[i + w] < c_age[i])) begin
                    c_ok[i]  = 1'b1;
                    c_idx[i] = c_idx[i + w];
                    c_age[i] = c_age[i + w];
                end
            end
        end
        s_best_found = c_ok[0];
        s_best_idx = c_idx[0];
        s_found = s_empty_found || s_best_found;
        s_idx = s_empty_found ? s_empty_idx : s_best_idx;
    end

    // Enqueue search: coalesce on a live equal entry, else first free entry.
    logic          e_match, e_free_found;
    logic [QW-1:0] e_free_idx;

    always_comb begin
        e_match = 1'b0;
        e_free_found = 1'b0;
        e_free_idx = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if ((r_qstat[i] == QS_DEMAND || r_qstat[i] == QS_PREFETCH)
                && r_qpage[i] == r_enq_page && r_qgen[i] == r_active_gen) begin
                e_match = 1'b1;
            end
            if (r_qstat[i] == QS_FREE) begin
                e_free_found = 1'b1;
                e_free_idx = QW'(i);
            end
        end
    end

    logic [SW-1:0] sidx_w;
    logic          sidx_ok;
    assign sidx_w  = SW'(r_sidx);
    assign sidx_ok = {28'd0, r_sidx} < 32'(SLOT_COUNT);

    logic [PAGE_W-1:0] pg_next;
    assign pg_next = r_spage[sidx_w] + 1'b1;

    // Sequenced updates of state and result. The result and the phase flags
    // are cleared when a word is captured.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_sstat[i] <= SS_EMPTY;
                r_spage[i] <= '0;
                r_sgen[i]  <= '0;
                r_spin[i]  <= '0;
                r_sage[i]  <= '0;
                r_sdem[i]  <= 1'b0;
            end
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                r_qstat[i] <= QS_FREE;
                r_qpage[i] <= '0;
                r_qgen[i]  <= '0;
            end
            r_clock <= '0;
            r_need_second <= 1'b0;
            r_need_enq <= 1'b0;
        end else if (i_cmd.capture) begin
            r_res <= '0;
            r_need_second <= 1'b0;
            r_need_enq <= 1'b0;
            r_enq_pf <= 1'b0;
        end else if (i_cmd.eval) begin
            r_last_page <= last_pg_full[PAGE_W-1:0];
            case (r_op)
                OP_LOOKUP: begin
                    if (range_bad) begin
                        r_res.status <= ST_RANGE;
                    end else begin
                        r_res.spans_two_pages <= spans;
                        if (!hit_found) begin
                            r_res.status <= ST_MISS;
                            r_res.page_number <= first_pg_full[PAGE_W-1:0];
                            r_enq_page <= first_pg_full[PAGE_W-1:0];
                            r_need_enq <= 1'b1;
                        end else begin
                            if (r_spin[hit_idx] != 8'hFF) r_spin[hit_idx] <= r_spin[hit_idx] + 1'b1;
                            r_first_hit <= hit_idx;
                            r_res.status <= ST_HIT;
                            r_res.first_slot <= 4'(hit_idx);
                            r_need_second <= spans;
                        end
                    end
                end
                OP_RELEASE: begin
                    if (sidx_ok && r_spin[sidx_w] != 8'd0) begin
                        r_spin[sidx_w] <= r_spin[sidx_w] - 1'b1;
                        r_res.status <= ST_RELEASED;
                    end else begin
                        r_res.status <= ST_REL_ERR;
                    end
                end
                OP_SERVICE: begin
                    if (!q_dem_found && !q_pf_found) begin
                        r_res.status <= ST_IDLE;
                    end else begin
                        r_qstat[q_idx] <= QS_FREE;
                        r_res.page_number <= r_qpage[q_idx];
                        r_res.fetch_is_prefetch <= !q_dem_found;
                        if (r_qgen[q_idx] != r_active_gen) begin
                            r_res.status <= ST_STALE;
                        end else if (!s_found) begin
                            r_res.status <= ST_NO_SLOT;
                            r_enq_page <= r_qpage[q_idx];
                            r_need_enq <= 1'b1;
                        end else begin
                            r_res.status <= ST_FETCH;
                            r_res.fetch_slot <= 4'(s_idx);
                            r_res.victim_evicted <= r_sstat[s_idx] == SS_READY;
                            r_sstat[s_idx] <= SS_LOADING;
                            r_spage[s_idx] <= r_qpage[q_idx];
                            r_sgen[s_idx] <= r_qgen[q_idx];
                            r_sdem[s_idx] <= q_dem_found;
                        end
                    end
                end
                default: begin
                    if (!sidx_ok || r_sstat[sidx_w] != SS_LOADING) begin
                        r_res.status <= ST_IDLE;
                    end else begin
                        r_sdem[sidx_w] <= 1'b0;
                        r_res.page_number <= r_spage[sidx_w];
                        r_res.fetch_slot <= r_sidx;
                        r_res.fetch_is_prefetch <= !r_sdem[sidx_w];
                        if (!r_ok) begin
                            r_sstat[sidx_w] <= SS_EMPTY;
                            r_res.status <= ST_CORRUPT;
                        end else if (r_sgen[sidx_w] != r_active_gen) begin
                            r_sstat[sidx_w] <= SS_EMPTY;
                            r_res.status <= ST_STALE;
                        end else begin
                            r_clock <= r_clock + 1'b1;
                            r_sage[sidx_w] <= r_clock + 1'b1;
                            r_sstat[sidx_w] <= SS_READY;
                            r_res.status <= ST_PUBLISHED;
                            if (r_sdem[sidx_w]
                                && ({1'b0, r_spage[sidx_w]} + 1'b1) < r_page_count) begin
                                r_enq_page <= pg_next;
                                r_enq_pf <= 1'b1;
                                r_need_enq <= 1'b1;
                            end
                        end
                    end
                end
            endcase
        end else if (i_cmd.second) begin
            r_need_second <= 1'b0;
            if (hit_found) begin
                if (r_spin[hit_idx] != 8'hFF) r_spin[hit_idx] <= r_spin[hit_idx] + 1'b1;
                r_res.second_slot <= 4'(hit_idx);
            end else begin
                if (r_spin[r_first_hit] != 8'd0) r_spin[r_first_hit] <= r_spin[r_first_hit] - 1'b1;
                r_res.status <= ST_MISS;
                r_res.first_slot <= '0;
                r_res.page_number <= r_last_page;
                r_enq_page <= r_last_page;
                r_need_enq <= 1'b1;
            end
        end else if (i_cmd.enq) begin
            r_need_enq <= 1'b0;
            if (e_match) begin
                r_res.enqueue_outcome <= EQ_COALESCE;
            end else if (e_free_found) begin
                r_qstat[e_free_idx] <= r_enq_pf ? QS_PREFETCH : QS_DEMAND;
                r_qpage[e_free_idx] <= r_enq_page;
                r_qgen[e_free_idx] <= r_active_gen;
                r_res.enqueue_outcome <= EQ_QUEUED;
            end else begin
                r_res.enqueue_outcome <= EQ_FULL;
            end
        end
    end

    // The status flags are read by the controller in the cycle after eval or a second-page lookup.
    always_comb begin
        o_stat.need_second = r_need_second;
        o_stat.need_enq = r_need_enq;
    end

    assign o_result = r_res;

endmodule

// ===== src/page_residency_cache_controller_top.sv =====
// Page residency cache controller: one word in, one result word out.
// From input acceptance a word passes through evaluate, check, an optional second-page lookup
// with another check, an optional enqueue, then output.
// A new word is accepted only after the previous result is emitted; output stalls hold it back.
// Reset is synchronous and active low; it empties all slots and the fetch queue.
module page_residency_cache_controller_top
    import prcc_pkg::*;
#(
    parameter int unsigned PAGE_FRAMES = 256,
    parameter int unsigned SLOT_COUNT  = 16,
    parameter int unsigned QUEUE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] operation, [33:2] start_frame, [49:34] frame_count,
    // [53:50] slot_index, [54] load_ok, [55] zero fill
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] status, [7:4] first_slot, [11:8] second_slot, [12] spans_two_pages,
    // [36:13] page_number, [40:37] fetch_slot, [41] fetch_is_prefetch,
    // [42] victim_evicted, [44:43] enqueue_outcome, [47:45] zero fill
    output logic [47:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cmd    cmd;
    t_stat   stat;
    t_result res;
    logic    r_out_valid;
    t_result r_out;
    logic    out_free;

    assign out_free = !r_out_valid || m_axis_tready;
    assign o_cfg_ready = 1'b1;

    prcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    prcc_dpath #(
        .PAGE_FRAMES (PAGE_FRAMES),
        .SLOT_COUNT  (SLOT_COUNT),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_operation   (s_axis_tdata[1:0]),
        .i_start_frame (s_axis_tdata[33:2]),
        .i_frame_count (s_axis_tdata[49:34]),
        .i_slot_index  (s_axis_tdata[53:50]),
        .i_load_ok     (s_axis_tdata[54]),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index[0]),
        .i_cfg_data    (i_cfg_data),
        .o_result      (res)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.emit) r_out <= res;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out};

`include "page_residency_cache_controller_top_assert.svh"

    `PRC_ASSERT_IMPL(a_emit_room, i_clk, i_rst_n, cmd.emit, out_free, "emit without room")
    `PRC_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, cmd.emit, m_axis_tvalid, "emit lost")
    `PRC_ASSERT_IMPL(a_status_range, i_clk, i_rst_n, m_axis_tvalid, r_out.status <= ST_PUBLISHED, "bad status")

endmodule
